[sv/vam_pkg.sv]
// Shared types, opcodes and saturation helpers for the vec3_alu block.
// Used by every module in this folder; depends on nothing.
package vam_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int SQ_STAGES     = 32;	// one root bit per stage, 64-bit radicand

	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_SUB   = 3'd1;
	localparam logic [2:0] OP_SCALE = 3'd2;
	localparam logic [2:0] OP_DIV   = 3'd3;
	localparam logic [2:0] OP_DOT   = 3'd4;
	localparam logic [2:0] OP_CROSS = 3'd5;
	localparam logic [2:0] OP_MAG   = 3'd6;
	localparam logic [2:0] OP_NORM  = 3'd7;

	localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

	localparam logic signed [65:0] W_MAX = 66'sd2147483647;
	localparam logic signed [65:0] W_MIN = -66'sd2147483648;

	typedef struct packed {
		logic [31:0] val;
		logic        flg;
	} sat_t;

	// item travelling alongside the root and divide pipelines
	typedef struct packed {
		logic [2:0]       op;
		logic [2:0][31:0] a;
		logic [31:0]      s;
		logic [2:0][31:0] r;
		logic [31:0]      sc;
		logic             flg;
	} side_t;

	typedef struct packed {
		logic             flg;
		logic [31:0]      sc;
		logic [2:0][31:0] r;
	} out_t;

	function automatic sat_t sat32(input logic signed [65:0] v);
		sat_t res;
		begin
			res.flg = 1'b0;
			if (v > W_MAX) begin
				res.val = S32_MAX;
				res.flg = 1'b1;
			end else if (v < W_MIN) begin
				res.val = S32_MIN;
				res.flg = 1'b1;
			end else begin
				res.val = v[31:0];
			end
			return res;
		end
	endfunction

	// magnitude of a signed 32-bit word; -2^31 gives 2^31
	function automatic logic [31:0] abs32(input logic [31:0] v);
		begin
			return v[31] ? (~v + 32'd1) : v;
		end
	endfunction

endpackage

[sv/vam_lane.sv]
// One vector lane: two multipliers, the add/subtract path and the
// per-component result for add, sub, scale and cross. Needs vam_pkg.
module vam_lane
	import vam_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               ce,
	input  logic [2:0]         op_in,
	input  logic [2:0]         op_s1,
	input  logic signed [31:0] add_a,
	input  logic signed [31:0] add_b,
	input  logic signed [31:0] m1x,
	input  logic signed [31:0] m1y,
	input  logic signed [31:0] m2x,
	input  logic signed [31:0] m2y,
	output logic signed [63:0] p1,
	output sat_t               res
);

	logic signed [63:0] p1_s1, p2_s1;
	logic signed [32:0] as_s1;
	logic signed [64:0] diff;
	sat_t               nxt;
	sat_t               res_s2;

	always_ff @(posedge clk) begin
		if (ce) begin
			p1_s1 <= m1x * m1y;
			p2_s1 <= m2x * m2y;
			as_s1 <= (op_in == OP_SUB) ? (33'(add_a) - 33'(add_b)) : (33'(add_a) + 33'(add_b));
		end
	end

	assign diff = 65'(p1_s1) - 65'(p2_s1);

	always_comb begin
		case (op_s1)
			OP_ADD:   nxt = sat32(66'(as_s1));
			OP_SUB:   nxt = sat32(66'(as_s1));
			OP_SCALE: nxt = sat32(66'(p1_s1 >>> FRAC_BITS));
			OP_CROSS: nxt = sat32(66'(diff >>> FRAC_BITS));
			default:  nxt = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			res_s2 <= nxt;
		end
	end

	assign p1  = p1_s1;
	assign res = res_s2;

endmodule

[sv/vam_sqrt.sv]
// Pipelined floor square root of a 64-bit radicand, one root bit per stage.
// Needs vam_pkg for the stage count.
module vam_sqrt
	import vam_pkg::*;
(
	input  logic        clk,
	input  logic        ce,
	input  logic [63:0] rad,
	output logic [31:0] root
);

	logic [63:0] rad_q  [SQ_STAGES];
	logic [33:0] rem_q  [SQ_STAGES];
	logic [31:0] root_q [SQ_STAGES];

	genvar k;
	generate
		for (k = 0; k < SQ_STAGES; k++) begin : g_st
			logic [63:0] rad_in;
			logic [33:0] rem_in;
			logic [31:0] root_in;
			logic [35:0] rs, trial;
			logic        ge;

			if (k == 0) begin : g_first
				assign rad_in  = rad;
				assign rem_in  = '0;
				assign root_in = '0;
			end else begin : g_next
				assign rad_in  = rad_q[k-1];
				assign rem_in  = rem_q[k-1];
				assign root_in = root_q[k-1];
			end

			assign rs    = {rem_in, rad_in[63:62]};
			assign trial = {2'b00, root_in, 2'b01};
			assign ge    = (rs >= trial);

			always_ff @(posedge clk) begin
				if (ce) begin
					rad_q[k]  <= {rad_in[61:0], 2'b00};
					rem_q[k]  <= ge ? 34'(rs - trial) : rs[33:0];
					root_q[k] <= {root_in[30:0], ge};
				end
			end
		end
	endgenerate

	assign root = root_q[SQ_STAGES-1];

endmodule

[sv/vam_div.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Dividend is a 32-bit magnitude shifted up by FRAC_BITS. Needs vam_pkg.
module vam_div
	import vam_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   ce,
	input  logic [32+FRAC_BITS-1:0] dvd,
	input  logic [31:0]            dvs,
	output logic [32+FRAC_BITS-1:0] quo
);

	localparam int DW = 32 + FRAC_BITS;

	logic [DW-1:0] qd_q  [DW];
	logic [31:0]   rem_q [DW];
	logic [31:0]   d_q   [DW];

	genvar j;
	generate
		for (j = 0; j < DW; j++) begin : g_st
			logic [DW-1:0] qd_in;
			logic [31:0]   rem_in, d_in;
			logic [32:0]   rs;
			logic          ge;

			if (j == 0) begin : g_first
				assign qd_in  = dvd;
				assign rem_in = '0;
				assign d_in   = dvs;
			end else begin : g_next
				assign qd_in  = qd_q[j-1];
				assign rem_in = rem_q[j-1];
				assign d_in   = d_q[j-1];
			end

			assign rs = {rem_in, qd_in[DW-1]};
			assign ge = (rs >= {1'b0, d_in});

			always_ff @(posedge clk) begin
				if (ce) begin
					qd_q[j]  <= {qd_in[DW-2:0], ge};
					rem_q[j] <= ge ? 32'(rs - {1'b0, d_in}) : rs[31:0];
					d_q[j]   <= d_in;
				end
			end
		end
	endgenerate

	assign quo = qd_q[DW-1];

endmodule

[sv/vec3_alu.sv]
// Top level of the three-component Q16.16 vector ALU.
// Instantiates vam_lane (x3), vam_sqrt and vam_div (x3); needs vam_pkg.
//
// Usage
//   s_* channel: one item = opcode (tuser) plus vectors a, b and a scalar
//   (tdata). m_* channel: one item = result vector, scalar and a
//   saturation flag. Each input item gives exactly one result item, in order.
//   Throughput: one item per cycle for every opcode mix while s_tready is high.
//   Path from acceptance to m_tvalid: two multiply/merge stages, 32 root
//   stages, 32 + FRAC_BITS divider stages (FRAC_BITS is 16 at Q16.16),
//   then the output register. Every item walks the full pipe so results
//   never reorder.
//   Three lanes handle x, y and z; the merge sums the lane products for dot
//   product and magnitude, and the single shared root feeds all three
//   dividers for normalize.
//   Stall: the pipe moves on a common enable. An output register plus one
//   skid entry sit behind it, so one more result is caught while a result
//   waits; s_tready drops only once the skid entry is full.
//   Reset: arst_n clears all valid flags; no payload is reset.
module vec3_alu
	import vam_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [223:0] s_tdata,	// a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
	input  logic [2:0]   s_tuser,	// opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,	// r_x, r_y, r_z, scalar_out
	output logic         m_tuser	// overflow_flag
);

	localparam int DW = 32 + FRAC_BITS;
	localparam int L  = SQ_STAGES + DW;	// side line depth
	localparam logic [DW-1:0] Q_POS_LIM = DW'(S32_MAX);
	localparam logic [DW-1:0] Q_NEG_LIM = DW'(S32_MIN);

	logic ce;

	// input unpacking
	logic [2:0]         op_in;
	logic signed [31:0] a_in [3];
	logic signed [31:0] b_in [3];
	logic signed [31:0] s_in;

	assign op_in = s_tuser;
	assign s_in  = s_tdata[223:192];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_in[i] = s_tdata[32*i +: 32];
			b_in[i] = s_tdata[96 + 32*i +: 32];
		end
	end

	// stage 1 / 2 sideband
	logic             v_s1, v_s2;
	logic [2:0]       op_s1, op_s2;
	logic [2:0][31:0] a_s1, a_s2;
	logic [31:0]      s_s1, s_s2;
	logic signed [65:0] sum_s2;

	logic signed [63:0] lane_p1 [3];
	sat_t               lane_res [3];

	genvar i;
	generate
		for (i = 0; i < 3; i++) begin : g_lane
			localparam int J = (i + 1) % 3;
			localparam int K = (i + 2) % 3;
			logic signed [31:0] m1x, m1y, m2x, m2y;

			// operand steering per opcode; cross uses the rotated components
			always_comb begin
				m1x = '0;
				m1y = '0;
				m2x = '0;
				m2y = '0;
				case (op_in)
					OP_SCALE: begin
						m1x = a_in[i];
						m1y = s_in;
					end
					OP_DOT: begin
						m1x = a_in[i];
						m1y = b_in[i];
					end
					OP_CROSS: begin
						m1x = a_in[J];
						m1y = b_in[K];
						m2x = a_in[K];
						m2y = b_in[J];
					end
					OP_MAG: begin
						m1x = a_in[i];
						m1y = a_in[i];
					end
					OP_NORM: begin
						m1x = a_in[i];
						m1y = a_in[i];
					end
					default: ;
				endcase
			end

			vam_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
				.clk   (clk),
				.ce    (ce),
				.op_in (op_in),
				.op_s1 (op_s1),
				.add_a (a_in[i]),
				.add_b (b_in[i]),
				.m1x   (m1x),
				.m1y   (m1y),
				.m2x   (m2x),
				.m2y   (m2y),
				.p1    (lane_p1[i]),
				.res   (lane_res[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (ce) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			op_s1  <= op_in;
			s_s1   <= s_in;
			a_s1   <= {a_in[2], a_in[1], a_in[0]};
			op_s2  <= op_s1;
			s_s2   <= s_s1;
			a_s2   <= a_s1;
			// merge: dot product sum, or sum of squares for the root
			sum_s2 <= 66'(lane_p1[0]) + 66'(lane_p1[1]) + 66'(lane_p1[2]);
		end
	end

	// entry into the side line
	sat_t  dot_sat;
	side_t e0;

	assign dot_sat = sat32(sum_s2 >>> FRAC_BITS);

	always_comb begin
		e0.op  = op_s2;
		e0.a   = a_s2;
		e0.s   = s_s2;
		e0.sc  = '0;
		e0.flg = lane_res[0].flg | lane_res[1].flg | lane_res[2].flg;
		for (int n = 0; n < 3; n++) begin
			e0.r[n] = lane_res[n].val;
		end
		if (op_s2 == OP_DOT) begin
			e0.sc  = dot_sat.val;
			e0.flg = e0.flg | dot_sat.flg;
		end
	end

	// shared root
	logic [31:0] root;

	vam_sqrt u_sqrt (
		.clk  (clk),
		.ce   (ce),
		.rad  (sum_s2[63:0]),
		.root (root)
	);

	// side line runs alongside the root and divide pipes
	side_t        line_q [L];
	logic [L-1:0] line_v;
	sat_t         mag_sat;

	assign mag_sat = sat32({34'd0, root});

	genvar k;
	generate
		for (k = 0; k < L; k++) begin : g_line
			side_t line_in;
			logic  v_in;

			if (k == 0) begin : g_head
				assign line_in = e0;
				assign v_in    = v_s2;
			end else if (k == SQ_STAGES) begin : g_mag
				// root lines up with the previous entry: fold in magnitude
				always_comb begin
					line_in = line_q[k-1];
					if (line_q[k-1].op == OP_MAG) begin
						line_in.sc  = mag_sat.val;
						line_in.flg = line_q[k-1].flg | mag_sat.flg;
					end
				end
				assign v_in = line_v[k-1];
			end else begin : g_body
				assign line_in = line_q[k-1];
				assign v_in    = line_v[k-1];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					line_v[k] <= 1'b0;
				end else if (ce) begin
					line_v[k] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (ce) begin
					line_q[k] <= line_in;
				end
			end
		end
	endgenerate

	// per-lane dividers: |a| * 2^F over |s| (divide) or over the root (normalize)
	side_t       t_div, t_end;
	logic [DW-1:0] quo [3];
	logic [31:0]   fin_r [3];
	logic          fin_f [3];
	logic          a_zero;

	assign t_div  = line_q[SQ_STAGES-1];
	assign t_end  = line_q[L-1];
	assign a_zero = (t_end.a[0] == '0) && (t_end.a[1] == '0) && (t_end.a[2] == '0);

	generate
		for (i = 0; i < 3; i++) begin : g_div
			logic [DW-1:0] dvd;
			logic [31:0]   dvs;
			logic          neg;
			sat_t          qs;

			assign dvd = {abs32(t_div.a[i]), {FRAC_BITS{1'b0}}};
			assign dvs = (t_div.op == OP_DIV) ? abs32(t_div.s) : root;

			vam_div #(.FRAC_BITS(FRAC_BITS)) u_div (
				.clk (clk),
				.ce  (ce),
				.dvd (dvd),
				.dvs (dvs),
				.quo (quo[i])
			);

			// quotient is a magnitude; truncation toward zero falls out
			assign neg = t_end.a[i][31] ^ ((t_end.op == OP_DIV) & t_end.s[31]);

			always_comb begin
				qs.flg = 1'b0;
				if (!neg) begin
					if (quo[i] > Q_POS_LIM) begin
						qs.val = S32_MAX;
						qs.flg = 1'b1;
					end else begin
						qs.val = quo[i][31:0];
					end
				end else begin
					if (quo[i] > Q_NEG_LIM) begin
						qs.val = S32_MIN;
						qs.flg = 1'b1;
					end else begin
						qs.val = ~quo[i][31:0] + 32'd1;
					end
				end
			end

			always_comb begin
				fin_r[i] = t_end.r[i];
				fin_f[i] = 1'b0;
				case (t_end.op)
					OP_DIV: begin
						if (t_end.s == '0) begin
							fin_r[i] = t_end.a[i][31] ? S32_MIN : S32_MAX;
							fin_f[i] = 1'b1;
						end else begin
							fin_r[i] = qs.val;
							fin_f[i] = qs.flg;
						end
					end
					OP_NORM: begin
						// zero vector passes through untouched
						if (a_zero) begin
							fin_r[i] = t_end.a[i];
						end else begin
							fin_r[i] = qs.val;
							fin_f[i] = qs.flg;
						end
					end
					default: ;
				endcase
			end
		end
	endgenerate

	// pipe output
	out_t p_d;
	logic p_v;

	assign p_v     = line_v[L-1];
	assign p_d.r   = {fin_r[2], fin_r[1], fin_r[0]};
	assign p_d.sc  = t_end.sc;
	assign p_d.flg = t_end.flg | fin_f[0] | fin_f[1] | fin_f[2];

	// output register and one skid entry
	logic o_v_q, k_v_q;
	out_t o_d_q, k_d_q;

	assign ce       = !k_v_q;
	assign s_tready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
			k_v_q <= 1'b0;
		end else if (!o_v_q || m_tready) begin
			if (k_v_q) begin
				o_v_q <= 1'b1;
				k_v_q <= 1'b0;
			end else begin
				o_v_q <= p_v;
			end
		end else if (ce && p_v) begin
			k_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!o_v_q || m_tready) begin
			o_d_q <= k_v_q ? k_d_q : p_d;
		end else if (ce && p_v) begin
			k_d_q <= p_d;
		end
	end

	assign m_tvalid = o_v_q;
	assign m_tdata  = {o_d_q.sc, o_d_q.r};
	assign m_tuser  = o_d_q.flg;

	// skid entry only ever backs up a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		k_v_q |-> o_v_q)
		else $error("skid holds an item while the output register is empty");

	// skid fills only when the output was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(k_v_q) |-> $past(o_v_q && !m_tready))
		else $error("skid filled without an output stall");

	// divide by zero always reports saturation
	a_div_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(p_v && (t_end.op == OP_DIV) && (t_end.s == '0)) |-> p_d.flg)
		else $error("zero divisor without overflow flag");

endmodule

[tb/sv/vec3_alu_chk.sv]
// Result checker for vec3_alu: watches both stream channels, predicts each
// result from the accepted operands and compares field by field.
// Depends on vam_pkg for the opcode constants.
module vec3_alu_chk
	import vam_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [223:0] s_tdata,
	input  logic [2:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,
	input  logic         m_tuser,
	output int           errors,
	output int           pending,
	output int           n_results
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic             flg;
		logic [31:0]      sc;
		logic [2:0][31:0] r;
	} vres_t;

	vres_t results_due[$];

	function automatic logic signed [127:0] floor_shift(input logic signed [127:0] v);
		return v >>> FRAC_BITS;
	endfunction

	function automatic logic [31:0] clamp32(input logic signed [127:0] v, ref logic flg);
		if (v > 128'sd2147483647) begin
			flg = 1'b1;
			return 32'h7fff_ffff;
		end
		if (v < -128'sd2147483648) begin
			flg = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic [63:0] floor_root(input logic [127:0] v);
		logic [63:0] root;
		root = 0;
		for (int i = 63; i >= 0; i--) begin
			root[i] = 1'b1;
			if ({64'd0, root} * {64'd0, root} > v)
				root[i] = 1'b0;
		end
		return root;
	endfunction

	// truncating quotient of two signed values
	function automatic logic signed [127:0] quot_trunc(input logic signed [127:0] n,
			input logic signed [127:0] d);
		logic signed [127:0] q;
		q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic vres_t vec3_result(input logic [2:0] op, input logic [223:0] d);
		logic signed [127:0] a[3], b[3], s, m, acc;
		logic [127:0] sq;
		vres_t res;
		logic flg;
		res = '0;
		flg = 1'b0;
		for (int i = 0; i < 3; i++) begin
			a[i] = $signed(d[32*i +: 32]);
			b[i] = $signed(d[96 + 32*i +: 32]);
		end
		s = $signed(d[192 +: 32]);
		case (op)
			OP_ADD: for (int i = 0; i < 3; i++) res.r[i] = clamp32(a[i] + b[i], flg);
			OP_SUB: for (int i = 0; i < 3; i++) res.r[i] = clamp32(a[i] - b[i], flg);
			OP_SCALE: for (int i = 0; i < 3; i++)
				res.r[i] = clamp32(floor_shift(a[i] * s), flg);
			OP_DIV: for (int i = 0; i < 3; i++) begin
				if (s == 0) begin
					flg = 1'b1;
					res.r[i] = (a[i] < 0) ? 32'h8000_0000 : 32'h7fff_ffff;
				end else
					res.r[i] = clamp32(quot_trunc(a[i] <<< FRAC_BITS, s), flg);
			end
			OP_DOT: begin
				acc = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
				res.sc = clamp32(floor_shift(acc), flg);
			end
			OP_CROSS: begin
				res.r[0] = clamp32(floor_shift(a[1]*b[2] - a[2]*b[1]), flg);
				res.r[1] = clamp32(floor_shift(a[2]*b[0] - a[0]*b[2]), flg);
				res.r[2] = clamp32(floor_shift(a[0]*b[1] - a[1]*b[0]), flg);
			end
			default: begin
				sq = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
				m = {64'd0, floor_root(sq)};
				if (op == OP_MAG)
					res.sc = clamp32(m, flg);
				else for (int i = 0; i < 3; i++)
					res.r[i] = (m == 0) ? a[i][31:0]
						: clamp32(quot_trunc(a[i] <<< FRAC_BITS, m), flg);
			end
		endcase
		res.flg = flg;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		vres_t got, want;
		if (!arst_n) begin
			errors    <= 0;
			n_results <= 0;
			results_due.delete();
		end else begin
			if (s_tvalid && s_tready)
				results_due.push_back(vec3_result(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata};
				n_results <= n_results + 1;
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors <= errors + 1;
				end else begin
					want = results_due.pop_front();
					for (int i = 0; i < 3; i++)
						if (got.r[i] !== want.r[i])
							$display("%0t: r[%0d] expected %h actual %h",
								$time, i, want.r[i], got.r[i]);
					if (got.sc !== want.sc)
						$display("%0t: scalar_out expected %h actual %h",
							$time, want.sc, got.sc);
					if (got.flg !== want.flg)
						$display("%0t: overflow_flag expected %b actual %b",
							$time, want.flg, got.flg);
					if (got !== want)
						errors <= errors + 1;
				end
			end
		end
	end

	assign pending = results_due.size();

endmodule

[tb/sv/vec3_alu_test.sv]
// Top of the vec3_alu testbench: clock, reset, operand stimulus, output
// back-pressure and verdict. Needs vec3_alu, vec3_alu_chk and vam_pkg.
module vec3_alu_test;
	import vam_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY   = 83;
	localparam int N_RANDOM  = 1130;
	localparam int IDLE_CAP  = 5000;	// cycles with no handshake before giving up

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [223:0] s_tdata = '0;	// a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
	logic [2:0]   s_tuser = OP_ADD;	// opcode
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;	// r_x, r_y, r_z, scalar_out
	logic         m_tuser;	// overflow_flag

	int  errors, pending, n_results;
	int  n_sent;
	int  op_count[8];
	bit  sink_busy_idle;	// sink idles at random while set
	bit  hold_sink;	// long hold-off request
	int  quiet;

	always #10 clk = ~clk;

	vec3_alu dut (.*);

	vec3_alu_chk chk (.*);

	// operand with a bias towards the edges of the range
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'h0001_0000;
			4: return 32'hffff_0000;
			5, 6: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
			default: return $urandom;
		endcase
	endfunction

	// send one item; idles for a random gap first when asked
	task automatic send_vec3(input logic [2:0] op, input logic [223:0] d, input bit gaps);
		if (gaps)
			while ($urandom_range(0, 99) < 33) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n_sent++;
		op_count[op]++;
		@(negedge clk);
	endtask

	function automatic logic [223:0] vec3_pack(input logic [31:0] ax, ay, az, bx, by, bz, sc);
		return {sc, bz, by, bx, az, ay, ax};
	endfunction

	// sink side: random stalls, or a long hold-off on request
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				m_tready <= 1'b0;
				for (hold = 0; hold < 300; hold++) @(negedge clk);
				hold_sink = 1'b0;
			end
			m_tready <= !(sink_busy_idle && $urandom_range(0, 99) < 33);
		end
	end

	// watchdog on handshakes
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > IDLE_CAP) begin
			$display("timeout, %0d results outstanding", pending);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic [2:0] op;
		int k;
		sink_busy_idle = 1'b0;
		hold_sink = 1'b0;
		n_sent = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: each operation, extremes, zero divisor, zero vector
		for (int o = 0; o < 8; o++) begin
			send_vec3(o[2:0], vec3_pack(32'h7fff_ffff, 32'h8000_0000, 32'h0001_8000,
				32'h7fff_ffff, 32'h7fff_ffff, 32'hfffe_0000, 32'h0002_0000), 1'b0);
			send_vec3(o[2:0], vec3_pack(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
				32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff), 1'b0);
		end
		send_vec3(OP_DIV, vec3_pack(32'h0, 32'h0005_0000, 32'hfff0_0000, 32'h0, 32'h0,
			32'h0, 32'h0), 1'b0);
		send_vec3(OP_NORM, '0, 1'b0);
		send_vec3(OP_MAG, '0, 1'b0);
		send_vec3(OP_NORM, vec3_pack(32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h0), 1'b0);
		send_vec3(OP_NORM, vec3_pack(32'h0003_0000, 32'hfffc_0000, 32'h0, 32'h0, 32'h0,
			32'h0, 32'h0), 1'b0);
		send_vec3(OP_SCALE, vec3_pack(32'hffff_ffff, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h1), 1'b0);

		// random, back to back with no idling at first
		for (k = 0; k < N_RANDOM; k++) begin
			if (k == 150)
				sink_busy_idle = 1'b1;
			if (k == 400)
				hold_sink = 1'b1;	// sink stalls while items keep coming
			if (k == 700) begin	// sender drains the pipe once
				s_tvalid <= 1'b0;
				@(negedge clk);
				while (pending != 0) @(negedge clk);
			end
			op = 3'($urandom_range(0, 7));
			send_vec3(op, vec3_pack(pick_word(), pick_word(), pick_word(), pick_word(),
				pick_word(), pick_word(), ($urandom_range(0, 15) == 0) ? 32'h0 : pick_word()),
				k >= 150);
		end
		s_tvalid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 20) @(negedge clk);
		$display("sent %0d items, %0d results checked", n_sent, n_results);
		$display("per opcode: add %0d sub %0d scale %0d div %0d dot %0d cross %0d mag %0d norm %0d",
			op_count[0], op_count[1], op_count[2], op_count[3],
			op_count[4], op_count[5], op_count[6], op_count[7]);
		if (errors == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[vec3_alu.f]
sv/vam_pkg.sv
sv/vam_lane.sv
sv/vam_sqrt.sv
sv/vam_div.sv
sv/vec3_alu.sv
tb/sv/vec3_alu_chk.sv
tb/sv/vec3_alu_test.sv
